### rtl/u2u_pkg.sv
// u2u_pkg: shared types and constants for the UTF-8 to UTF-16 transcoder.
// Holds the channel payload structs, the front-to-back queue entry and sizes.
// No dependencies.
package u2u_pkg;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_end;
    } t_in_item;

    // Result transaction payload
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
    } t_out_item;

    // Decoded code point, classified by the front part
    typedef struct packed {
        logic        pair;
        logic [20:0] code_point;
    } t_cp_item;

    // Write port of the code point queue
    typedef struct packed {
        logic     valid;
        t_cp_item item;
    } t_cp_push;

    // Code point queue depth and pointer width
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Code point limits
    localparam logic [20:0] BMP_MAX    = 21'h00FFFF;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h010000;

    // Surrogate bases and continuation payload mask
    localparam logic [15:0] HI_SUR_BASE = 16'hD800;
    localparam logic [15:0] LO_SUR_BASE = 16'hDC00;
    localparam logic [7:0]  CONT_MASK   = 8'h3F;

endpackage

### rtl/u2u_front.sv
// u2u_front: accepts UTF-8 bytes, tracks open sequences and classifies
// finished code points for the queue. Depends on u2u_pkg.
module u2u_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  u2u_pkg::t_in_item i_in_item,
    output u2u_pkg::t_cp_push o_push
);

    localparam logic [7:0] CONT_MASK = u2u_pkg::CONT_MASK;

    logic [1:0]  r_pending;
    logic [1:0]  n_pending;
    logic [20:0] r_partial;
    logic [20:0] n_partial;
    logic [20:0] w_cp;
    logic        w_done;
    logic [7:0]  w_byte;

    assign w_byte = i_in_item.data_byte;

    // Decode one byte against the open sequence
    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        w_cp      = 21'd0;
        w_done    = 1'b0;
        if (r_pending != 2'd0) begin
            w_cp      = {r_partial[14:0], w_byte[5:0] & CONT_MASK[5:0]};
            n_pending = r_pending - 2'd1;
            n_partial = w_cp;
            if (r_pending == 2'd1) begin
                w_done    = 1'b1;
                n_partial = 21'd0;
            end
        end else begin
            case (w_byte) inside
                8'b0???????: begin
                    w_cp   = {13'd0, w_byte};
                    w_done = 1'b1;
                end
                8'b110?????: begin
                    n_partial = {16'd0, w_byte[4:0]};
                    n_pending = 2'd1;
                end
                8'b1110????: begin
                    n_partial = {17'd0, w_byte[3:0]};
                    n_pending = 2'd2;
                end
                8'b11110???: begin
                    n_partial = {18'd0, w_byte[2:0]};
                    n_pending = 2'd3;
                end
                default: begin
                    n_pending = r_pending;
                end
            endcase
        end
        // Drop any partial sequence at string end
        if (i_in_item.string_end) begin
            n_pending = 2'd0;
            n_partial = 21'd0;
        end
    end

    // Push in-range code points, flag those that need a pair
    always_comb begin
        o_push.valid           = i_accept && w_done && (w_cp <= u2u_pkg::CP_MAX);
        o_push.item.pair       = (w_cp > u2u_pkg::BMP_MAX);
        o_push.item.code_point = w_cp;
    end

    // Advance sequence state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= 21'd0;
        end else if (i_accept) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_in_item.string_end |=> (r_pending == 2'd0) && (r_partial == 21'd0))
        else $error("sequence state not cleared after string end");

    a_idle_partial_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == 2'd0) |-> (r_partial == 21'd0))
        else $error("partial code point held with no sequence open");

    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> i_accept && !(o_push.item.pair && (w_cp[20:16] == 5'd0)))
        else $error("push without accepted byte or misclassified pair");

endmodule

### rtl/u2u_queue.sv
// u2u_queue: short queue of classified code points between front and back.
// Depends on u2u_pkg.
module u2u_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  u2u_pkg::t_cp_push i_push,
    input  logic              i_pop,
    output u2u_pkg::t_cp_item o_head,
    output logic              o_empty,
    output logic              o_full
);

    localparam int AW = u2u_pkg::Q_AW;

    u2u_pkg::t_cp_item r_entry [u2u_pkg::Q_DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_empty = (r_count == (AW+1)'(0));
    assign o_full  = (r_count == (AW+1)'(u2u_pkg::Q_DEPTH));
    assign o_head  = r_entry[r_rd_ptr];
    assign w_wr    = i_push.valid && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_entry[r_wr_ptr] <= i_push.item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(u2u_pkg::Q_DEPTH))
        else $error("queue occupancy beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != (AW+1)'(0)) && (r_count != (AW+1)'(u2u_pkg::Q_DEPTH))
        |-> (r_wr_ptr - r_rd_ptr) == r_count[AW-1:0])
        else $error("queue pointers disagree with occupancy");

    a_push_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("code point pushed into full queue");

endmodule

### rtl/u2u_back.sv
// u2u_back: turns queued code points into UTF-16 code units, one per cycle while
// i_pop keeps up, through an output register. Depends on u2u_pkg.
module u2u_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  u2u_pkg::t_cp_item  i_head,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output u2u_pkg::t_out_item o_out_item
);

    logic               r_out_valid;
    logic               r_lo_pending;
    logic [15:0]        r_lo_unit;
    u2u_pkg::t_out_item r_out;
    logic               w_free;
    logic [20:0]        w_off;
    logic [15:0]        w_hi;
    logic [15:0]        w_lo;

    assign o_empty    = !r_out_valid;
    assign o_out_item = r_out;
    assign w_free     = !r_out_valid || i_pop;
    assign o_q_pop    = w_free && !r_lo_pending && !i_q_empty;

    // Split a supplementary code point into surrogates
    assign w_off = i_head.code_point - u2u_pkg::SUPP_BASE;
    assign w_hi  = u2u_pkg::HI_SUR_BASE | {6'd0, w_off[19:10]};
    assign w_lo  = u2u_pkg::LO_SUR_BASE | {6'd0, w_off[9:0]};

    // Load output register: pending low surrogate first, then queue head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_lo_pending <= 1'b0;
        end else if (w_free) begin
            if (r_lo_pending) begin
                r_out_valid  <= 1'b1;
                r_lo_pending <= 1'b0;
            end else if (!i_q_empty) begin
                r_out_valid  <= 1'b1;
                r_lo_pending <= i_head.pair;
            end else begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_lo_pending) begin
                r_out.code_unit <= r_lo_unit;
                r_out.run_last  <= 1'b1;
            end else if (!i_q_empty) begin
                r_out.code_unit <= i_head.pair ? w_hi : i_head.code_point[15:0];
                r_out.run_last  <= !i_head.pair;
                r_lo_unit       <= w_lo;
            end
        end
    end

    a_hi_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo_pending |-> r_out_valid && !r_out.run_last)
        else $error("low surrogate pending without high surrogate shown");

    a_lo_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo_pending && i_pop |=> r_out_valid && r_out.run_last)
        else $error("low surrogate did not follow high surrogate");

    a_no_pop_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo_pending |-> !o_q_pop)
        else $error("queue popped while pair incomplete");

endmodule

### rtl/utf8_to_utf16_transcoder_unit.sv
// utf8_to_utf16_transcoder_unit: top level of the UTF-8 to UTF-16 transcoder.
// Instantiates u2u_front, u2u_queue and u2u_back; uses u2u_pkg.
//
//   Channel   Direction  Handshake            Payload
//   input     in         push / full          i_in_item  (data_byte, string_end)
//   result    out        pop / empty          o_out_item (code_unit, run_last)
//
// One byte is accepted per cycle while the four-entry code point queue has room.
// A BMP code point leaves as one unit and a surrogate pair as two, one unit per cycle
// while pop keeps up, through the back part's single output register.
// A byte's unit passes through a queue entry, then the back part's output register.
// Reset is synchronous and active low; it clears sequence state, the queue and output valid.
// A stall on pop backs up the queue and then raises full.
module utf8_to_utf16_transcoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  u2u_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output u2u_pkg::t_out_item o_out_item
);

    u2u_pkg::t_cp_push w_push;
    u2u_pkg::t_cp_item w_head;
    logic              w_q_empty;
    logic              w_q_full;
    logic              w_q_pop;
    logic              w_accept;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    u2u_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_in_item (i_in_item),
        .o_push    (w_push)
    );

    u2u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_q_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    u2u_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_item (o_out_item)
    );

endmodule
